// ===== design/sft_pkg.sv =====
`default_nettype none
package sft_pkg;

  // Width of the byte field on the request channel.
  localparam int unsigned BYTE_W = 8;

  // Start, parity and stop bits framed around the data bits.
  localparam int unsigned FRAME_OVERHEAD = 3;

  // Depth of the result queue ahead of the output port.
  localparam int unsigned OUTQ_DEPTH = 2;

  // Request kinds carried by the action field.
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_START_LEVEL = 1'b0,
    REG_STOP_LEVEL  = 1'b1
  } cfg_reg_t;

  // One line level as it travels to the output port.
  typedef logic line_bit_t;

endpackage
`default_nettype wire

// ===== design/serial_frame_transmitter_fifo.sv =====
`default_nettype none
// Serial frame transmitter with a byte ring buffer. One request can be accepted
// in each clock while the result queue is not full. A write request stores
// data_byte in the ring buffer (no full check, so an overflow overwrites unsent
// bytes); a tick request returns one line_bit result: start level, DATA_BITS
// data bits LSB first, even parity, stop level, then one gap bit of 0, and 0
// when idle. The levels are taken when a frame starts. The byte of a frame is
// read from the buffer memory in the tick that starts the frame and is used
// from the following tick on. Results pass through a two-entry queue, so
// requests keep flowing while one result waits at the output. The buffer has
// no clearing pass after reset.
module serial_frame_transmitter_fifo #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned DATA_BITS    = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic                       cfg_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic                       in_action,
  input  wire logic [sft_pkg::BYTE_W-1:0] in_data_byte,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic                       out_line_bit
);

  import sft_pkg::*;

  localparam int unsigned AW        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned FRAME_LEN = DATA_BITS + FRAME_OVERHEAD;
  localparam int unsigned PW        = $clog2(FRAME_LEN + 1);

  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]        wr_idx_r, wr_idx_nxt;
  logic                 wrapped_r, wrapped_nxt;
  logic                 active_r, active_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 stop_lvl_r, stop_lvl_nxt;
  logic                 start_cfg_r;
  logic                 stop_cfg_r;
  logic                 in_acc;
  logic                 is_tick;
  logic                 is_write;
  logic                 load;
  logic                 full;
  line_bit_t            line_bit;
  logic [DATA_BITS-1:0] frame_byte;
  logic [FRAME_LEN-1:0] frame_vec;

  assign in_stall = full;
  assign in_acc   = in_valid && !in_stall;
  assign is_tick  = in_acc && (action_t'(in_action) == ACT_TICK);
  assign is_write = in_acc && (action_t'(in_action) == ACT_WRITE);

  // A tick starts a frame when idle and the buffer holds unsent bytes.
  assign load = is_tick && !active_r && (rd_idx_r != wr_idx_r) &&
                ((rd_idx_r < wr_idx_r) || wrapped_r);

  // Byte store: written by write requests, read once per frame.
  sft_store #(
    .DEPTH (BUFFER_DEPTH),
    .WIDTH (DATA_BITS),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (is_write),
    .wr_addr   (wr_idx_r),
    .wr_data   (in_data_byte[DATA_BITS-1:0]),
    .rd_en     (load),
    .rd_addr   (rd_idx_r),
    .rd_data_r (frame_byte)
  );

  // Frame as sent; the start position is covered by the loading tick itself.
  assign frame_vec = {stop_lvl_r, ^frame_byte, frame_byte, start_cfg_r};

  // Index, flag and bit-position update for the accepted request.
  always_comb begin
    rd_idx_nxt   = rd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    wrapped_nxt  = wrapped_r;
    active_nxt   = active_r;
    pos_nxt      = pos_r;
    stop_lvl_nxt = stop_lvl_r;
    line_bit     = 1'b0;
    if (is_write) begin
      if (wr_idx_r == AW'(BUFFER_DEPTH - 1)) begin
        wr_idx_nxt  = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wr_idx_nxt = wr_idx_r + AW'(1);
      end
    end
    if (load) begin
      if (rd_idx_r == AW'(BUFFER_DEPTH - 1)) begin
        rd_idx_nxt  = '0;
        wrapped_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + AW'(1);
      end
      active_nxt   = 1'b1;
      pos_nxt      = PW'(1);
      stop_lvl_nxt = stop_cfg_r;
      line_bit     = start_cfg_r;
    end else if (is_tick && active_r) begin
      if (pos_r < PW'(FRAME_LEN)) begin
        line_bit = frame_vec[pos_r];
        pos_nxt  = pos_r + PW'(1);
      end else begin
        active_nxt = 1'b0;
        pos_nxt    = '0;
      end
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      wrapped_r   <= 1'b0;
      active_r    <= 1'b0;
      pos_r       <= '0;
      start_cfg_r <= 1'b1;
      stop_cfg_r  <= 1'b0;
    end else begin
      rd_idx_r  <= rd_idx_nxt;
      wr_idx_r  <= wr_idx_nxt;
      wrapped_r <= wrapped_nxt;
      active_r  <= active_nxt;
      pos_r     <= pos_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_START_LEVEL: start_cfg_r <= cfg_data;
          REG_STOP_LEVEL:  stop_cfg_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    stop_lvl_r <= stop_lvl_nxt;
  end

  // Result queue ahead of the output port.
  sft_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (is_tick),
    .push_bit     (line_bit),
    .full         (full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_line_bit (out_line_bit)
  );

`ifndef SYNTH
  a_active_pos: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ((pos_r != '0) && (pos_r <= PW'(FRAME_LEN))))
    else $error("bit position out of range during a frame");

  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (pos_r == '0))
    else $error("bit position not cleared while idle");

  a_read_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (rd_idx_r != $past(rd_idx_r)) |-> $past(load))
    else $error("read index moved without a frame load");
`endif

endmodule
`default_nettype wire

// ===== design/sft_store.sv =====
`default_nettype none
module sft_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port; entries hold whatever was last written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/sft_outq.sv =====
`default_nettype none
module sft_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sft_pkg::line_bit_t push_bit,
  output      logic               full,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      sft_pkg::line_bit_t out_line_bit
);

  import sft_pkg::*;

  localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  line_bit_t     head_r, head_nxt;
  line_bit_t     tail_r, tail_nxt;
  logic          pop;

  assign pop          = out_valid && !out_stall;
  assign out_valid    = (count_r != '0);
  assign out_line_bit = head_r;
  assign full         = (count_r == CW'(OUTQ_DEPTH));

  // Two-entry queue: the head feeds the port, the tail takes a request
  // while the head is stalled.
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    unique case ({push, pop})
      2'b10: begin
        if (count_r == '0) begin
          head_nxt = push_bit;
        end else begin
          tail_nxt = push_bit;
        end
        count_nxt = count_r + CW'(1);
      end
      2'b01: begin
        head_nxt  = tail_r;
        count_nxt = count_r - CW'(1);
      end
      2'b11: begin
        if (count_r == CW'(1)) begin
          head_nxt = push_bit;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_bit;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy is control state; the entries need no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(OUTQ_DEPTH))
    else $error("result queue occupancy out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("result pushed into a full queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue occupancy did not grow on push");
`endif

endmodule
`default_nettype wire

// ===== test/sft_line_checker.sv =====
module sft_line_checker #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned DATA_BITS    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic                       cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_action,
  input  logic [sft_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_line_bit,
  output int                         fail_count,
  output int                         pending_results
);
  import sft_pkg::*;

  localparam int unsigned FRAME_LEN = DATA_BITS + FRAME_OVERHEAD;
  localparam int unsigned IDX_W     = $clog2(BUFFER_DEPTH);
  localparam int unsigned POS_W     = $clog2(FRAME_LEN + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

  // Shadow copy of the transmitter: ring buffer, indexes and frame shifter.
  logic [DATA_BITS-1:0] byte_store [BUFFER_DEPTH];
  logic [IDX_W-1:0]     rd_ptr;
  logic [IDX_W-1:0]     wr_ptr;
  logic                 wrapped;
  logic                 frame_busy;
  logic [POS_W-1:0]     bit_pos;
  logic [FRAME_LEN-1:0] frame_shift;
  logic                 start_level;
  logic                 stop_level;

  // Line levels still owed by the block, oldest first.
  line_bit_t expected_bits[$];
  int        errors = 0;

  // A write request stores the byte; the write index wraps and marks the wrap.
  function automatic void store_byte(logic [BYTE_W-1:0] value);
    byte_store[wr_ptr] = value[DATA_BITS-1:0];
    if (wr_ptr == LAST_IDX) begin
      wr_ptr  = '0;
      wrapped = 1'b1;
    end else begin
      wr_ptr++;
    end
  endfunction

  // A tick request yields one line level, loading a new frame when idle.
  function automatic line_bit_t next_line_bit();
    logic [DATA_BITS-1:0] data;
    line_bit_t            level;
    level = 1'b0;
    if (!frame_busy && rd_ptr != wr_ptr && (rd_ptr < wr_ptr || wrapped)) begin
      data = byte_store[rd_ptr];
      if (rd_ptr == LAST_IDX) begin
        rd_ptr  = '0;
        wrapped = 1'b0;
      end else begin
        rd_ptr++;
      end
      frame_shift = {stop_level, ^data, data, start_level};
      bit_pos     = '0;
      frame_busy  = 1'b1;
    end
    if (frame_busy) begin
      if (bit_pos < FRAME_LEN) begin
        level = frame_shift[bit_pos];
        bit_pos++;
      end else begin
        // Gap tick after the stop bit sends 0 and frees the shifter.
        bit_pos    = '0;
        frame_busy = 1'b0;
      end
    end
    return level;
  endfunction

  // Watch the configuration port and both channels at every rising edge.
  always @(posedge clk) begin : watch
    line_bit_t want;
    if (!rst_n) begin
      rd_ptr      = '0;
      wr_ptr      = '0;
      wrapped     = 1'b0;
      frame_busy  = 1'b0;
      bit_pos     = '0;
      frame_shift = '0;
      start_level = 1'b1;
      stop_level  = 1'b0;
      expected_bits.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_START_LEVEL) begin
          start_level = cfg_data;
        end else begin
          stop_level = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACT_WRITE) begin
          store_byte(in_data_byte);
        end else begin
          expected_bits.push_back(next_line_bit());
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_bits.size() == 0) begin
          $error("line_bit: no result expected, actual %0b", out_line_bit);
          errors++;
        end else begin
          want = expected_bits.pop_front();
          if (out_line_bit !== want) begin
            $error("line_bit mismatch: expected %0b, actual %0b", want, out_line_bit);
            errors++;
          end
        end
      end
    end
    pending_results <= expected_bits.size();
    fail_count      <= errors;
  end

endmodule

// ===== test/tb_serial_frame_transmitter_fifo.sv =====
module tb_serial_frame_transmitter_fifo;
  import sft_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned BUFFER_DEPTH_TB = 64;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_we       = 1'b0;
  cfg_reg_t          cfg_index    = REG_START_LEVEL;
  logic              cfg_data     = 1'b0;
  logic              in_valid     = 1'b0;
  action_t           in_action    = ACT_TICK;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              out_stall    = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_line_bit;
  int                fail_count;
  int                pending_results;

  // When set, neither side inserts gaps or stalls.
  bit steady = 1'b0;

  always #5 clk = ~clk;

  serial_frame_transmitter_fifo DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_line_bit (out_line_bit)
  );

  sft_line_checker u_line_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_bit    (out_line_bit),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // Bytes lean towards the all-zero and all-one extremes now and then.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one request after a random gap and hold it until it is taken.
  task automatic send_request(action_t kind, logic [BYTE_W-1:0] value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= kind;
    in_data_byte <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every line level has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both levels are written with no request in flight and every result returned.
  task automatic set_levels(logic start_lvl, logic stop_lvl);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_LEVEL;
    cfg_data  <= start_lvl;
    @(posedge clk);
    cfg_index <= REG_STOP_LEVEL;
    cfg_data  <= stop_lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks, with short bursts of writes a little faster than the line drains.
  task automatic run_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 13) == 0) begin
        repeat ($urandom_range(1, 3)) send_request(ACT_WRITE, pick_byte());
      end else begin
        send_request(ACT_TICK, pick_byte());
      end
    end
  endtask

  // Result side: a random stall before each result.
  initial begin : result_sink
    int hold;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Idle line, then frames of the all-one and all-zero bytes.
    send_request(ACT_TICK, '1);
    send_request(ACT_WRITE, '1);
    send_request(ACT_WRITE, '0);
    repeat (22) send_request(ACT_TICK, pick_byte());

    // Finish the second frame, then fill the buffer exactly so that the write
    // index wraps onto the read index; the line must stay idle until one more
    // write, which overwrites an unsent byte. Draining it later wraps the read
    // index too.
    repeat (4) send_request(ACT_TICK, pick_byte());
    repeat (BUFFER_DEPTH_TB) send_request(ACT_WRITE, pick_byte());
    repeat (4) send_request(ACT_TICK, pick_byte());
    send_request(ACT_WRITE, pick_byte());
    run_traffic(70);

    set_levels(1'b0, 1'b1);
    run_traffic(70);

    steady = 1'b1;
    set_levels(1'b1, 1'b1);
    run_traffic(50);
    steady = 1'b0;

    set_levels(1'b0, 1'b0);
    run_traffic(50);

    set_levels(1'b1, 1'b0);
    run_traffic(25);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
